[hdl/otf_pkg.sv]
`default_nettype none
package otf_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int THRESH_W     = 15;
    localparam int THRESH_RESET = 14746;
    localparam int NW           = 16;
    localparam int OW           = 16;
    localparam int VW           = 19;
    localparam int MW           = VW - 1;
    localparam int SW           = 2 * MW;
    localparam int RB           = MW;
    localparam int RW           = SW + 1;
    localparam int QB           = FRAC_BITS + 1;
    localparam int NUMW         = MW + FRAC_BITS;
    localparam int PW           = 2 * NW;
    localparam int XW           = PW + 2;

    function automatic logic signed [VW-1:0] shr_rnd(input logic signed [XW-1:0] p);
        logic [XW-1:0] m;
        logic [XW-1:0] r;
        m = p[XW-1] ? XW'(-p) : XW'(p);
        r = (m + (XW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return p[XW-1] ? -$signed(VW'(r)) : $signed(VW'(r));
    endfunction

endpackage
`default_nettype wire

[hdl/orthonormal_tangent_frame.sv]
// Channel   Dir  Payload
// cfg       in   cfg_wr_data: axis switch threshold (15 bits)
// s_axis    in   s_tdata: normal x, y, z (16 bits each)
// m_axis    out  m_tdata: first tangent x, y, z, second tangent x, y, z;
//                m_tuser: frame degenerate
//
// One transaction per cycle sustained while m_tready does not stall; the data path holds
// two 18-stage square-root pipelines and two 15-stage divider pipelines.
// Reset clears the valid bits and loads the threshold default.
// A stall on m_tready freezes the whole pipeline and drops s_tready.
`default_nettype none
module orthonormal_tangent_frame (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [otf_pkg::THRESH_W-1:0]      cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [3*otf_pkg::NW-1:0]          s_tdata,   // normal_x, normal_y, normal_z
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [6*otf_pkg::OW-1:0]          m_tdata,   // first_tangent_x/y/z, second_tangent_x/y/z
    output logic [0:0]                        m_tuser    // frame_degenerate
);
    import otf_pkg::*;

    localparam int S1W = 3 * OW;
    localparam int S2W = 3 * OW + 1;

    logic                  en;
    logic [THRESH_W-1:0]   thr_reg;
    logic signed [NW-1:0]  n_in [3];
    logic [NW:0]           nz_mag;

    logic                  v1_reg;
    logic signed [NW-1:0]  n1_reg [3];
    logic                  usex1_reg;
    logic                  v2_reg;
    logic signed [PW-1:0]  p2_reg [3];
    logic                  usex2_reg;
    logic signed [NW-1:0]  n2_reg [3];
    logic                  v3_reg;
    logic signed [VW-1:0]  u3_reg [3];
    logic signed [NW-1:0]  n3_reg [3];

    logic                  nv1;
    logic signed [OW-1:0]  un1 [3];
    logic                  zu1;
    logic [S1W-1:0]        side1;
    logic signed [NW-1:0]  nn1 [3];

    logic                  v4_reg;
    logic signed [PW-1:0]  c4_reg [6];
    logic signed [OW-1:0]  u4_reg [3];
    logic                  degu4_reg;
    logic                  v5_reg;
    logic signed [VW-1:0]  t5_reg [3];
    logic signed [OW-1:0]  u5_reg [3];
    logic                  degu5_reg;

    logic                  nv2;
    logic signed [OW-1:0]  tn2 [3];
    logic                  zt2;
    logic [S2W-1:0]        side2;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign n_in[0] = $signed(s_tdata[NW-1:0]);
    assign n_in[1] = $signed(s_tdata[2*NW-1:NW]);
    assign n_in[2] = $signed(s_tdata[3*NW-1:2*NW]);
    assign nz_mag  = n_in[2][NW-1] ? (NW+1)'(-(NW+1)'(n_in[2])) : (NW+1)'(n_in[2]);

    assign nn1[0] = $signed(side1[NW-1:0]);
    assign nn1[1] = $signed(side1[2*NW-1:NW]);
    assign nn1[2] = $signed(side1[3*NW-1:2*NW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESH_W'(THRESH_RESET);
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
            if (en)
            begin
                v1_reg <= s_tvalid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= nv1;
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg    <= n_in;
            usex1_reg <= nz_mag > (NW+1)'(thr_reg);

            for (int i = 0; i < 3; i++)
                p2_reg[i] <= (usex1_reg ? n1_reg[0] : n1_reg[2]) * n1_reg[i];
            usex2_reg <= usex1_reg;
            n2_reg    <= n1_reg;

            u3_reg[0] <= (usex2_reg ? VW'(1 << FRAC_BITS) : VW'(0)) - shr_rnd(XW'(p2_reg[0]));
            u3_reg[1] <= -shr_rnd(XW'(p2_reg[1]));
            u3_reg[2] <= (usex2_reg ? VW'(0) : VW'(1 << FRAC_BITS)) - shr_rnd(XW'(p2_reg[2]));
            n3_reg    <= n2_reg;

            c4_reg[0] <= nn1[1] * un1[2];
            c4_reg[1] <= nn1[2] * un1[1];
            c4_reg[2] <= nn1[2] * un1[0];
            c4_reg[3] <= nn1[0] * un1[2];
            c4_reg[4] <= nn1[0] * un1[1];
            c4_reg[5] <= nn1[1] * un1[0];
            u4_reg    <= un1;
            degu4_reg <= zu1;

            for (int i = 0; i < 3; i++)
                t5_reg[i] <= shr_rnd(XW'(c4_reg[2*i]) - XW'(c4_reg[2*i+1]));
            u5_reg    <= u4_reg;
            degu5_reg <= degu4_reg;
        end
    end

    otf_norm #(
        .SIDE_W (S1W)
    ) u_norm_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_vec    (u3_reg),
        .in_side   ({n3_reg[2], n3_reg[1], n3_reg[0]}),
        .out_valid (nv1),
        .out_vec   (un1),
        .out_zero  (zu1),
        .out_side  (side1)
    );

    otf_norm #(
        .SIDE_W (S2W)
    ) u_norm_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .in_vec    (t5_reg),
        .in_side   ({degu5_reg, u5_reg[2], u5_reg[1], u5_reg[0]}),
        .out_valid (nv2),
        .out_vec   (tn2),
        .out_zero  (zt2),
        .out_side  (side2)
    );

    assign m_tvalid   = nv2;
    assign m_tdata    = {tn2[2], tn2[1], tn2[0], side2[3*OW-1:0]};
    assign m_tuser[0] = side2[3*OW] | zt2;

endmodule
`default_nettype wire

[hdl/otf_norm.sv]
`default_nettype none
module otf_norm #(
    parameter int SIDE_W = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [otf_pkg::VW-1:0]    in_vec [3],
    input  logic        [SIDE_W-1:0]         in_side,
    output logic                             out_valid,
    output logic signed [otf_pkg::OW-1:0]    out_vec [3],
    output logic                             out_zero,
    output logic        [SIDE_W-1:0]         out_side
);
    import otf_pkg::*;

    logic              a_valid_reg;
    logic [MW-1:0]     a_mag_reg [3];
    logic [2:0]        a_neg_reg;
    logic [SW-1:0]     a_sq_reg [3];
    logic [SIDE_W-1:0] a_side_reg;

    logic [RB:0]       r_valid_reg;
    logic [SW-1:0]     r_rem_reg [RB+1];
    logic [RW-1:0]     r_res_reg [RB+1];
    logic [MW-1:0]     r_mag_reg [RB+1][3];
    logic [2:0]        r_neg_reg [RB+1];
    logic [SIDE_W-1:0] r_side_reg [RB+1];
    logic [SW-1:0]     r_rem_next [RB];
    logic [RW-1:0]     r_res_next [RB];
    logic [RW-1:0]     r_trial [RB];

    logic [QB:0]       d_valid_reg;
    logic [NUMW-1:0]   d_rem_reg [QB+1][3];
    logic [QB-1:0]     d_q_reg [QB+1][3];
    logic [RB-1:0]     d_len_reg [QB+1];
    logic [2:0]        d_neg_reg [QB+1];
    logic [QB:0]       d_zero_reg;
    logic [SIDE_W-1:0] d_side_reg [QB+1];
    logic [NUMW-1:0]   d_rem_next [QB][3];
    logic [QB-1:0]     d_q_next [QB][3];
    logic [NUMW:0]     d_dv [QB];

    logic              o_valid_reg;
    logic signed [OW-1:0] o_vec_reg [3];
    logic              o_zero_reg;
    logic [SIDE_W-1:0] o_side_reg;

    logic [RB-1:0]     root;
    logic [SW+1:0]     sq_sum;

    assign root   = r_res_reg[RB][RB-1:0];
    assign sq_sum = (SW+2)'(a_sq_reg[0]) + (SW+2)'(a_sq_reg[1]) + (SW+2)'(a_sq_reg[2]);

    always_comb
    begin
        for (int k = 0; k < RB; k++)
        begin
            r_trial[k] = r_res_reg[k] + (RW'(1) << (2 * (RB - 1 - k)));
            if ({1'b0, r_rem_reg[k]} >= r_trial[k])
            begin
                r_rem_next[k] = r_rem_reg[k] - r_trial[k][SW-1:0];
                r_res_next[k] = (r_res_reg[k] >> 1) + (RW'(1) << (2 * (RB - 1 - k)));
            end
            else
            begin
                r_rem_next[k] = r_rem_reg[k];
                r_res_next[k] = r_res_reg[k] >> 1;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < QB; k++)
        begin
            d_dv[k] = (NUMW+1)'(d_len_reg[k]) << (QB - 1 - k);
            for (int i = 0; i < 3; i++)
            begin
                if ({1'b0, d_rem_reg[k][i]} >= d_dv[k])
                begin
                    d_rem_next[k][i] = d_rem_reg[k][i] - d_dv[k][NUMW-1:0];
                    d_q_next[k][i]   = d_q_reg[k][i] | (QB'(1) << (QB - 1 - k));
                end
                else
                begin
                    d_rem_next[k][i] = d_rem_reg[k][i];
                    d_q_next[k][i]   = d_q_reg[k][i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            r_valid_reg <= '0;
            d_valid_reg <= '0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            r_valid_reg <= {r_valid_reg[RB-1:0], a_valid_reg};
            d_valid_reg <= {d_valid_reg[QB-1:0], r_valid_reg[RB]};
            o_valid_reg <= d_valid_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_mag_reg[i] <= in_vec[i][VW-1] ? MW'(-in_vec[i]) : MW'(in_vec[i]);
                a_neg_reg[i] <= in_vec[i][VW-1];
                a_sq_reg[i]  <= (in_vec[i][VW-1] ? MW'(-in_vec[i]) : MW'(in_vec[i]))
                              * (in_vec[i][VW-1] ? MW'(-in_vec[i]) : MW'(in_vec[i]));
            end
            a_side_reg <= in_side;

            r_rem_reg[0]  <= sq_sum[SW-1:0];
            r_res_reg[0]  <= '0;
            r_mag_reg[0]  <= a_mag_reg;
            r_neg_reg[0]  <= a_neg_reg;
            r_side_reg[0] <= a_side_reg;
            for (int k = 0; k < RB; k++)
            begin
                r_rem_reg[k+1]  <= r_rem_next[k];
                r_res_reg[k+1]  <= r_res_next[k];
                r_mag_reg[k+1]  <= r_mag_reg[k];
                r_neg_reg[k+1]  <= r_neg_reg[k];
                r_side_reg[k+1] <= r_side_reg[k];
            end

            for (int i = 0; i < 3; i++)
            begin
                d_rem_reg[0][i] <= {r_mag_reg[RB][i], FRAC_BITS'(0)} + NUMW'(root >> 1);
                d_q_reg[0][i]   <= '0;
            end
            d_len_reg[0]  <= root;
            d_neg_reg[0]  <= r_neg_reg[RB];
            d_zero_reg[0] <= (root == '0);
            d_side_reg[0] <= r_side_reg[RB];
            for (int k = 0; k < QB; k++)
            begin
                d_rem_reg[k+1]  <= d_rem_next[k];
                d_q_reg[k+1]    <= d_q_next[k];
                d_len_reg[k+1]  <= d_len_reg[k];
                d_neg_reg[k+1]  <= d_neg_reg[k];
                d_zero_reg[k+1] <= d_zero_reg[k];
                d_side_reg[k+1] <= d_side_reg[k];
            end

            for (int i = 0; i < 3; i++)
            begin
                if (d_zero_reg[QB])
                    o_vec_reg[i] <= '0;
                else if (d_neg_reg[QB][i])
                    o_vec_reg[i] <= -$signed(OW'(d_q_reg[QB][i]));
                else
                    o_vec_reg[i] <= $signed(OW'(d_q_reg[QB][i]));
            end
            o_zero_reg <= d_zero_reg[QB];
            o_side_reg <= d_side_reg[QB];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_vec   = o_vec_reg;
    assign out_zero  = o_zero_reg;
    assign out_side  = o_side_reg;

endmodule
`default_nettype wire

[bench/testbench.sv]
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import otf_pkg::*;

    typedef struct packed {
        logic signed [15:0] nz;
        logic signed [15:0] ny;
        logic signed [15:0] nx;
    } normal_t;

    typedef struct packed {
        logic [15:0] ux;
        logic [15:0] uy;
        logic [15:0] uz;
        logic [15:0] tx;
        logic [15:0] ty;
        logic [15:0] tz;
        logic        degenerate;
    } frame_t;

    localparam int LATENCY = 79;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [THRESH_W-1:0]   cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [3*NW-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [6*OW-1:0]       m_tdata;
    logic [0:0]            m_tuser;

    normal_t pending_normals[$];
    frame_t  expected_frames[$];
    logic [THRESH_W-1:0] threshold;
    int  mismatches;
    bit  s_taken;
    bit  hold_off_sink;
    int  hold_off_cycles;
    int  burst_left;
    int  gap_left;
    int  idle_cycles;

    orthonormal_tangent_frame u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint round_shift(input longint p);
        longint m;
        m = (p < 0) ? -p : p;
        m = (m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (p < 0) ? -m : m;
    endfunction

    function automatic longint round_div(input longint num, input longint den);
        longint m;
        m = (num < 0) ? -num : num;
        m = (m + den / 2) / den;
        return (num < 0) ? -m : m;
    endfunction

    function automatic longint floor_sqrt(input longint s);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > s)
            b = b >>> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic bit unit_scale(inout longint v[3]);
        longint s;
        longint len;
        s = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        if (s == 0)
            return 1'b1;
        len = floor_sqrt(s);
        for (int i = 0; i < 3; i++)
            v[i] = round_div(v[i] * (64'sd1 <<< FRAC_BITS), len);
        return 1'b0;
    endfunction

    function automatic logic [15:0] clamp16(input longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    function automatic frame_t predict_frame(input normal_t nrm, input logic [THRESH_W-1:0] thr);
        longint n[3];
        longint u[3];
        longint t[3];
        longint axis[3];
        longint d;
        longint az;
        bit deg_u;
        bit deg_t;
        frame_t f;
        n[0] = nrm.nx;
        n[1] = nrm.ny;
        n[2] = nrm.nz;
        axis = '{0, 0, 0};
        az = (n[2] < 0) ? -n[2] : n[2];
        if (az > longint'(thr))
        begin
            axis[0] = 64'sd1 <<< FRAC_BITS;
            d = n[0];
        end
        else
        begin
            axis[2] = 64'sd1 <<< FRAC_BITS;
            d = n[2];
        end
        for (int i = 0; i < 3; i++)
            u[i] = axis[i] - round_shift(d * n[i]);
        deg_u = unit_scale(u);
        t[0] = round_shift(n[1] * u[2] - n[2] * u[1]);
        t[1] = round_shift(n[2] * u[0] - n[0] * u[2]);
        t[2] = round_shift(n[0] * u[1] - n[1] * u[0]);
        deg_t = unit_scale(t);
        f.ux = clamp16(u[0]);
        f.uy = clamp16(u[1]);
        f.uz = clamp16(u[2]);
        f.tx = clamp16(t[0]);
        f.ty = clamp16(t[1]);
        f.tz = clamp16(t[2]);
        f.degenerate = deg_u | deg_t;
        return f;
    endfunction

    function automatic normal_t make_normal(input int x, input int y, input int z);
        normal_t nrm;
        nrm.nx = 16'(x);
        nrm.ny = 16'(y);
        nrm.nz = 16'(z);
        return nrm;
    endfunction

    function automatic int rand_comp();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $signed(16'($urandom));
        if (r == 1)
            return $urandom_range(0, 1) ? 16384 : -16384;
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic normal_t rand_unit_normal();
        real x;
        real y;
        real z;
        real l;
        x = real'(int'($urandom_range(0, 20000)) - 10000);
        y = real'(int'($urandom_range(0, 20000)) - 10000);
        z = real'(int'($urandom_range(0, 20000)) - 10000);
        if ($urandom_range(0, 3) == 0)
            z = z * 20.0;
        l = $sqrt(x * x + y * y + z * z);
        if (l < 1.0)
            return make_normal(0, 0, 16384);
        return make_normal($rtoi(x / l * 16384.0), $rtoi(y / l * 16384.0),
                           $rtoi(z / l * 16384.0));
    endfunction

    always @(posedge clk)
    begin
        s_taken <= rst_n && s_tvalid && s_tready;
    end

    // sender: bursts and gaps
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_taken)
                void'(pending_normals.pop_front());
            if (!s_tvalid || s_taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_normals.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_normals[0];
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: own stall pattern, long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_sink)
            m_tready <= 1'b0;
        else
        begin
            case (($urandom_range(0, 255) >> 6) & 3)
                0: m_tready <= ($urandom_range(0, 3) != 0);
                1: m_tready <= 1'b1;
                2: m_tready <= ($urandom_range(0, 1) != 0);
                default: m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            if (hold_off_cycles == 1)
                hold_off_sink <= 1'b0;
        end
    end

    // predict on input transaction, check on output transaction
    always @(posedge clk)
    begin
        frame_t want;
        frame_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_frames.push_back(predict_frame(normal_t'(s_tdata), threshold));
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                       m_tdata[79:64], m_tdata[95:80], m_tuser[0]};
                if (expected_frames.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output transaction %h", got);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $write("mismatch: expected u=%0d,%0d,%0d t=%0d,%0d,%0d deg=%0d; ",
                                $signed(want.ux), $signed(want.uy), $signed(want.uz),
                                $signed(want.tx), $signed(want.ty), $signed(want.tz),
                                want.degenerate);
                            $display("got u=%0d,%0d,%0d t=%0d,%0d,%0d deg=%0d",
                                $signed(got.ux), $signed(got.uy), $signed(got.uz),
                                $signed(got.tx), $signed(got.ty), $signed(got.tz),
                                got.degenerate);
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic drain();
        while (pending_normals.size() != 0 || expected_frames.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        threshold = value;
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++)
            if ($urandom_range(0, 3) == 0)
                pending_normals.push_back(make_normal(rand_comp(), rand_comp(), rand_comp()));
            else
                pending_normals.push_back(rand_unit_normal());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tdata = '0;
        s_tvalid = 1'b0;
        m_tready = 1'b0;
        mismatches = 0;
        hold_off_sink = 1'b0;
        hold_off_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        idle_cycles = 0;
        threshold = THRESH_W'(THRESH_RESET);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pending_normals.push_back(make_normal(0, 0, 16384));
        pending_normals.push_back(make_normal(0, 0, -16384));
        pending_normals.push_back(make_normal(16384, 0, 0));
        pending_normals.push_back(make_normal(0, 16384, 0));
        pending_normals.push_back(make_normal(-16384, -16384, -16384));
        pending_normals.push_back(make_normal(0, 0, 0));
        pending_normals.push_back(make_normal(0, 0, 14746));
        pending_normals.push_back(make_normal(0, 0, 14747));
        pending_normals.push_back(make_normal(7141, 0, -14746));
        pending_normals.push_back(make_normal(7140, 0, -14747));
        pending_normals.push_back(make_normal(16384, 0, 16384));
        pending_normals.push_back(make_normal(-32768, -32768, -32768));
        pending_normals.push_back(make_normal(32767, 32767, 32767));
        pending_normals.push_back(make_normal(32767, -32768, 0));
        pending_normals.push_back(make_normal(9459, 9459, 9459));
        pending_normals.push_back(make_normal(1, 1, 1));
        pending_normals.push_back(make_normal(-1, 0, 0));
        drain();

        write_threshold(THRESH_W'(0));
        pending_normals.push_back(make_normal(0, 0, 0));
        pending_normals.push_back(make_normal(100, 0, 1));
        pending_normals.push_back(make_normal(16384, 0, 1));
        queue_random(120);
        drain();

        write_threshold(THRESH_W'(16384));
        queue_random(150);
        drain();

        write_threshold(THRESH_W'(32767));
        pending_normals.push_back(make_normal(0, -32768, -32768));
        queue_random(100);
        // long receiver hold-off while items keep coming
        hold_off_sink = 1'b1;
        hold_off_cycles = 400;
        queue_random(150);
        drain();

        write_threshold(THRESH_W'(14746));
        queue_random(200);
        drain();

        write_threshold(THRESH_W'($urandom_range(0, 32767)));
        queue_random(200);
        drain();

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
